### hw/rtl/ball_tracking_motion_sequencer_assert.svh
// assertion macros for the ball tracking motion sequencer checks
`ifndef BALL_TRACKING_MOTION_SEQUENCER_ASSERT_SVH
`define BALL_TRACKING_MOTION_SEQUENCER_ASSERT_SVH

// property checked while out of reset
`define BTMS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that must also hold across reset
`define BTMS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/btms_pkg.sv
// package: types, codes and constants of the ball tracking motion sequencer
package btms_pkg;

  localparam int COORD_BITS    = 10;
  localparam int RADIUS_BITS   = 9;
  localparam int CFG_DATA_BITS = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int AMT_BITS      = 11;
  localparam int AMT_CALC_BITS = (COORD_BITS + 1 > AMT_BITS) ? COORD_BITS + 1 : AMT_BITS;
  localparam int BAND_BITS     = RADIUS_BITS + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEAD_BAND    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REACH_RADIUS = 2'd2;

  localparam logic [COORD_BITS-1:0]  CENTER_X_RST     = COORD_BITS'(50);
  localparam logic [RADIUS_BITS-1:0] DEAD_BAND_RST    = RADIUS_BITS'(10);
  localparam logic [RADIUS_BITS-1:0] REACH_RADIUS_RST = RADIUS_BITS'(130);

  // event kinds
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_TIMER = 3'd1;
  localparam logic [2:0] KIND_NONE  = 3'd2;
  localparam logic [2:0] KIND_MULTI = 3'd3;
  localparam logic [2:0] KIND_BALL  = 3'd4;

  // turn codes
  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_LEFT  = 2'd1;
  localparam logic [1:0] TURN_RIGHT = 2'd2;

  // mode codes as reported
  localparam logic [1:0] MODE_CODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_CODE_RIGHT  = 2'd1;
  localparam logic [1:0] MODE_CODE_LEFT   = 2'd2;
  localparam logic [1:0] MODE_CODE_LOCKED = 2'd3;

  localparam logic [6:0]          SPEED_FULL   = 7'd100;
  localparam logic [6:0]          SPEED_SLOW   = 7'd20;
  localparam logic [6:0]          SPEED_STOP   = 7'd0;
  localparam logic [AMT_BITS-1:0] AMT_TRACK    = 11'd70;
  localparam logic [AMT_BITS-1:0] AMT_SEARCH   = 11'd200;
  localparam logic [AMT_BITS-1:0] AMT_VERIFY   = 11'd100;
  localparam logic [AMT_BITS-1:0] AMT_MAX      = 11'd2047;
  localparam logic [9:0]          DELAY_INIT   = 10'd1;
  localparam logic [9:0]          DELAY_ROT    = 10'd200;
  localparam logic [9:0]          DELAY_HIGH   = 10'd800;
  localparam logic [9:0]          DELAY_VERIFY = 10'd300;

  typedef enum logic [3:0] {
    MODE_SEARCH = 4'b0001,
    MODE_RIGHT  = 4'b0010,
    MODE_LEFT   = 4'b0100,
    MODE_LOCKED = 4'b1000
  } mode_t;

  typedef enum logic [4:0] {
    STEP_ROT_LOW   = 5'b00001,
    STEP_ROT_HIGH  = 5'b00010,
    STEP_VERIFY    = 5'b00100,
    STEP_VERIFY_TB = 5'b01000,
    STEP_STOP      = 5'b10000
  } search_step_t;

  typedef struct packed {
    logic [2:0]             kind;
    logic [COORD_BITS-1:0]  ball_x;
    logic [RADIUS_BITS-1:0] ball_radius;
  } in_item_t;

  typedef struct packed {
    logic                speed_valid;
    logic [6:0]          speed;
    logic [1:0]          turn;
    logic [AMT_BITS-1:0] turn_amount;
    logic                go_forward;
    logic                delay_start;
    logic [9:0]          delay_value;
    logic                want_repeat_detect;
    logic                want_single_detect;
    logic [1:0]          mode_now;
  } out_item_t;

  // position error summary handed from the error unit to the step logic
  typedef struct packed {
    logic                pos;
    logic                neg;
    logic [AMT_BITS-1:0] amount;
  } err_info_t;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    case (m)
      MODE_SEARCH: c = MODE_CODE_SEARCH;
      MODE_RIGHT:  c = MODE_CODE_RIGHT;
      MODE_LEFT:   c = MODE_CODE_LEFT;
      MODE_LOCKED: c = MODE_CODE_LOCKED;
      default:     c = MODE_CODE_SEARCH;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/btms_err.sv
// position error unit: dead band test and saturated turn amount
module btms_err (
  input  logic [btms_pkg::COORD_BITS-1:0]  ball_x,
  input  logic [btms_pkg::RADIUS_BITS-1:0] ball_radius,
  input  logic [btms_pkg::COORD_BITS-1:0]  center_x,
  input  logic [btms_pkg::RADIUS_BITS-1:0] dead_band,
  output btms_pkg::err_info_t              err
);
  import btms_pkg::*;

  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS-1:0]      mag;
  logic [BAND_BITS-1:0]       band;
  logic                       in_band;
  logic [AMT_CALC_BITS-1:0]   dbl;

  assign diff    = $signed({1'b0, ball_x}) - $signed({1'b0, center_x});
  assign mag     = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
  assign band    = BAND_BITS'(dead_band) + BAND_BITS'(ball_radius);
  // strictly inside lo..hi is the same as |x - c| < band
  assign in_band = ({{BAND_BITS{1'b0}}, mag} < {{COORD_BITS{1'b0}}, band});
  assign dbl     = AMT_CALC_BITS'({mag, 1'b0});

  always_comb begin
    err.pos    = !in_band && !diff[COORD_BITS] && (diff != '0);
    err.neg    = !in_band && diff[COORD_BITS];
    err.amount = (dbl > AMT_CALC_BITS'(AMT_MAX)) ? AMT_MAX : dbl[AMT_BITS-1:0];
  end

endmodule

### hw/rtl/btms_step.sv
// sequencer state and per-event command logic
module btms_step (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic [2:0]                       kind,
  input  logic [btms_pkg::RADIUS_BITS-1:0] ball_radius,
  input  logic [btms_pkg::RADIUS_BITS-1:0] reach_radius,
  input  btms_pkg::err_info_t              err,
  output btms_pkg::out_item_t              res
);
  import btms_pkg::*;

  mode_t        mode_r, mode_nxt;
  search_step_t step_r, step_nxt;
  logic         tracking_r, tracking_nxt;

  logic far_enough;
  logic confirmed;

  assign far_enough = (ball_radius > reach_radius);

  always_comb begin
    res          = '0;
    mode_nxt     = mode_r;
    step_nxt     = step_r;
    tracking_nxt = tracking_r;
    confirmed    = 1'b0;

    // detection confirm, shared by several-balls and ball-seen in search
    if ((kind == KIND_MULTI && tracking_r) || kind == KIND_BALL) begin
      if (mode_r == MODE_SEARCH) begin
        if (step_r == STEP_ROT_LOW || step_r == STEP_ROT_HIGH) begin
          res.speed_valid        = 1'b1;
          res.speed              = SPEED_STOP;
          res.want_single_detect = 1'b1;
          step_nxt               = STEP_VERIFY;
        end
        confirmed = (step_r == STEP_VERIFY) || (step_r == STEP_VERIFY_TB);
        if (confirmed) begin
          step_nxt               = STEP_STOP;
          res.want_repeat_detect = 1'b1;
        end
      end
    end

    case (kind)
      KIND_START: begin
        if (mode_r == MODE_SEARCH) begin
          res.want_repeat_detect = 1'b1;
          res.delay_start        = 1'b1;
          res.delay_value        = DELAY_INIT;
          step_nxt               = STEP_ROT_HIGH;
        end
        tracking_nxt = 1'b1;
      end
      KIND_TIMER: begin
        if (mode_r == MODE_SEARCH) begin
          case (step_r)
            STEP_ROT_LOW: begin
              res.speed_valid = 1'b1;
              res.speed       = SPEED_FULL;
              res.turn        = TURN_LEFT;
              res.turn_amount = AMT_SEARCH;
              res.delay_start = 1'b1;
              res.delay_value = DELAY_ROT;
              step_nxt        = STEP_ROT_HIGH;
            end
            STEP_ROT_HIGH: begin
              res.speed_valid = 1'b1;
              res.speed       = SPEED_SLOW;
              res.turn        = TURN_LEFT;
              res.turn_amount = AMT_SEARCH;
              res.delay_start = 1'b1;
              res.delay_value = DELAY_HIGH;
              step_nxt        = STEP_ROT_LOW;
            end
            STEP_VERIFY: begin
              res.go_forward  = 1'b1;
              res.speed_valid = 1'b1;
              res.speed       = SPEED_STOP;
            end
            STEP_VERIFY_TB: begin
              res.want_repeat_detect = 1'b1;
              res.delay_start        = 1'b1;
              res.delay_value        = DELAY_INIT;
              step_nxt               = STEP_ROT_HIGH;
            end
            default: begin
            end
          endcase
        end
      end
      KIND_NONE: begin
        if (tracking_r) begin
          if (mode_r == MODE_SEARCH) begin
            if (step_r == STEP_VERIFY) begin
              res.speed_valid = 1'b1;
              res.speed       = SPEED_SLOW;
              res.turn        = TURN_RIGHT;
              res.turn_amount = AMT_VERIFY;
              res.delay_start = 1'b1;
              res.delay_value = DELAY_VERIFY;
              step_nxt        = STEP_VERIFY_TB;
            end
          end else begin
            if (mode_r == MODE_RIGHT || mode_r == MODE_LEFT) begin
              mode_nxt = MODE_SEARCH;
            end
            res.speed_valid = 1'b1;
            res.speed       = SPEED_STOP;
          end
        end
      end
      KIND_MULTI: begin
        if (tracking_r) begin
          if (mode_r == MODE_SEARCH) begin
            if (confirmed) begin
              mode_nxt        = MODE_RIGHT;
              res.speed_valid = 1'b1;
              res.speed       = SPEED_FULL;
              res.turn        = TURN_RIGHT;
              res.turn_amount = AMT_TRACK;
            end
          end else begin
            res.speed_valid = 1'b1;
            res.speed       = SPEED_STOP;
          end
        end
      end
      KIND_BALL: begin
        if (mode_r != MODE_SEARCH || confirmed) begin
          if (err.pos) begin
            if (mode_r == MODE_RIGHT) begin
              res.turn        = TURN_RIGHT;
              res.turn_amount = err.amount;
            end else begin
              mode_nxt        = MODE_RIGHT;
              res.speed_valid = 1'b1;
              res.speed       = SPEED_FULL;
              res.turn        = TURN_RIGHT;
              res.turn_amount = AMT_TRACK;
            end
          end else if (err.neg) begin
            if (mode_r == MODE_LEFT) begin
              res.turn        = TURN_LEFT;
              res.turn_amount = err.amount;
            end else begin
              mode_nxt        = MODE_LEFT;
              res.speed_valid = 1'b1;
              res.speed       = SPEED_FULL;
              res.turn        = TURN_LEFT;
              res.turn_amount = AMT_TRACK;
            end
          end else if (mode_r == MODE_LOCKED) begin
            res.go_forward = 1'b1;
            if (far_enough) begin
              res.speed_valid = 1'b1;
              res.speed       = SPEED_STOP;
            end
          end else begin
            mode_nxt        = MODE_LOCKED;
            res.speed_valid = 1'b1;
            res.speed       = far_enough ? SPEED_STOP : SPEED_FULL;
          end
        end
      end
      default: begin
      end
    endcase

    res.mode_now = mode_code(mode_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_SEARCH;
      step_r     <= STEP_STOP;
      tracking_r <= 1'b0;
    end else if (adv) begin
      mode_r     <= mode_nxt;
      step_r     <= step_nxt;
      tracking_r <= tracking_nxt;
    end
  end

endmodule

### hw/rtl/ball_tracking_motion_sequencer.sv
// top level of the ball tracking motion sequencer
//
// usage
// - input channel in_valid/in_ready/in_data: one beat per robot event
//   (start, timer expiry, no ball, several balls, ball seen at x with radius)
// - result channel out_valid/out_ready/out_data: exactly one motor command
//   beat per input beat, in order, carrying the mode after the event
// - config channel cfg_valid/cfg_ready/cfg_index/cfg_data: always ready,
//   writes center_x, dead_band and reach_radius; other indexes are dropped
// - an accepted beat passes the input register and then the result register,
//   and shows on out_valid once it is held in the result register
// - throughput: one beat per cycle unless the result side stalls; the event
//   logic is a single pass between the input register and the result register
// - reset (rst_n low, synchronous): both pipeline registers empty, mode
//   search, search sub-step stop, tracking off, registers at defaults
// - when the receiver stalls, the result register holds, the input register
//   fills, and in_ready drops once both are occupied
module ball_tracking_motion_sequencer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  btms_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output btms_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [btms_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [btms_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import btms_pkg::*;

  // configuration registers
  logic [COORD_BITS-1:0]  center_x_r;
  logic [RADIUS_BITS-1:0] dead_band_r;
  logic [RADIUS_BITS-1:0] reach_radius_r;

  // input register stage
  in_item_t  s1_data_r;
  logic      s1_valid_r;
  // result register stage
  out_item_t out_data_r;
  logic      out_valid_r;

  logic      s1_adv;
  err_info_t err;
  out_item_t res;

  // stage 1 moves into the result register when that register is free
  // or being emptied this cycle
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= CENTER_X_RST;
      dead_band_r    <= DEAD_BAND_RST;
      reach_radius_r <= REACH_RADIUS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:     center_x_r     <= cfg_data[COORD_BITS-1:0];
        REG_DEAD_BAND:    dead_band_r    <= cfg_data[RADIUS_BITS-1:0];
        REG_REACH_RADIUS: reach_radius_r <= cfg_data[RADIUS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // position error from the held event
  btms_err u_err (
    .ball_x      (s1_data_r.ball_x),
    .ball_radius (s1_data_r.ball_radius),
    .center_x    (center_x_r),
    .dead_band   (dead_band_r),
    .err         (err)
  );

  // mode, sub-step and tracking update only when the event moves on
  btms_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (s1_adv),
    .kind         (s1_data_r.kind),
    .ball_radius  (s1_data_r.ball_radius),
    .reach_radius (reach_radius_r),
    .err          (err),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

endmodule

### hw/rtl/btms_checker.sv
// port-level checks for the ball tracking motion sequencer, bound to the top
`include "ball_tracking_motion_sequencer_assert.svh"

module btms_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input btms_pkg::out_item_t out_data
);
  import btms_pkg::*;

  logic in_beat;
  logic stall;
  logic fields_clean;

  assign in_beat      = in_valid && in_ready;
  assign stall        = out_valid && !out_ready;
  assign fields_clean = (out_data.turn != TURN_NONE || out_data.turn_amount == '0) &&
                        (out_data.delay_start || out_data.delay_value == '0) &&
                        (out_data.speed_valid || out_data.speed == '0);

  // reset leaves no result pending
  `BTMS_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid, "result pending after reset")

  // a stalled result beat holds
  `BTMS_ASSERT(a_stall_hold, clk, rst_n, stall |=> out_valid && $stable(out_data), "beat changed")

  // every accepted event yields a result
  `BTMS_ASSERT(a_accept_result, clk, rst_n, in_beat |-> ##2 out_valid, "no result for event")

  // unused command fields stay zero
  `BTMS_ASSERT(a_zero_fields, clk, rst_n, out_valid |-> fields_clean, "inactive field not zero")

endmodule

bind ball_tracking_motion_sequencer btms_checker u_btms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
